// ----- rtl/ncmd_pkg.sv -----
// Shared types and constants for the nearest-cluster block.
`default_nettype none
package ncmd_pkg;
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int CFG_NUM_CLUSTERS = 0;
   localparam int CFG_REPS         = 1;
   localparam int CFG_NUM_ENTRIES  = 2;

   localparam int CLUSTER_BITS = 5;
   localparam int REPS_BITS    = 7;
   localparam int ENTRIES_BITS = 9;
   localparam int MEAN_BITS    = 17;

   // Configuration snapshot handed from the front part to the back part.
   typedef struct packed {
      logic [CLUSTER_BITS-1:0] clusters;
      logic [REPS_BITS-1:0]    divisor;
      logic [ENTRIES_BITS-1:0] entries;
   } cfg_type;
endpackage
`default_nettype wire

// ----- rtl/ncmd_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ncmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/ncmd_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module ncmd_isqrt #(
   parameter int IN_BITS = 34
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [IN_BITS-1:0]   radicand,
   output logic                      done,
   output logic [(IN_BITS+1)/2-1:0]  root
);
   localparam int RB = (IN_BITS + 1) / 2;
   localparam int NB = 2 * RB;
   localparam int CB = $clog2(RB + 1);

   logic [NB-1:0] rem_ff, rem_in;     // radicand bits not yet consumed
   logic [RB+1:0] part_ff, part_in;   // partial remainder
   logic [RB-1:0] res_ff, res_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_in;
   logic [RB+1:0] shifted;
   logic [RB+1:0] trial;

   assign root = res_ff;

   always_comb begin
      rem_in  = rem_ff;
      part_in = part_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // restoring digit step: bring down two radicand bits, try res*4+1
      shifted = {part_ff[RB-1:0], rem_ff[NB-1 -: 2]};
      trial   = {res_ff, 2'b01};
      if (start) begin
         rem_in  = NB'(radicand);
         part_in = '0;
         res_in  = '0;
         cnt_in  = CB'(RB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= trial) begin
            part_in = shifted - trial;
            res_in  = {res_ff[RB-2:0], 1'b1};
         end else begin
            part_in = shifted;
            res_in  = {res_ff[RB-2:0], 1'b0};
         end
         rem_in = {rem_ff[NB-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done    <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      part_ff <= part_in;
   end
endmodule
`default_nettype wire

// ----- rtl/ncmd_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ncmd_divider #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] dividend,
   input  wire logic [DEN_BITS-1:0] divisor,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quotient
);
   logic [NUM_BITS-1:0]             q_ff, q_in;
   logic [DEN_BITS:0]               r_ff, r_in;
   logic [DEN_BITS-1:0]             d_ff, d_in;
   logic [$clog2(NUM_BITS+1)-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in, done_in;
   logic [DEN_BITS+1:0]             trial;

   assign quotient = q_ff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; trial = '0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = ($clog2(NUM_BITS+1))'(NUM_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[NUM_BITS-1]};
         if (trial >= (DEN_BITS+2)'(d_ff)) begin
            r_in = (DEN_BITS+1)'(trial - (DEN_BITS+2)'(d_ff));
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = (DEN_BITS+1)'(trial);
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end
endmodule
`default_nettype wire

// ----- rtl/ncmd_front.sv -----
// Front part: register file, command decode, table writes, query queue.
`default_nettype none
module ncmd_front #(
   parameter int TABLE_DEPTH  = 256,
   parameter int MAX_CLUSTERS = 16,
   parameter int COORD_BITS   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          req_kind,
   input  wire logic [7:0]                    req_entry_index,
   input  wire logic signed [COORD_BITS-1:0]  req_point_x,
   input  wire logic signed [COORD_BITS-1:0]  req_point_y,
   input  wire logic [ncmd_pkg::CLUSTER_BITS-1:0] req_entry_cluster,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [3:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               busy,
   output logic                               tbl_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]     tbl_wr_addr,
   output logic [2*COORD_BITS+ncmd_pkg::CLUSTER_BITS-1:0] tbl_wr_data,
   output logic                               q_valid,
   output logic signed [COORD_BITS-1:0]       q_x,
   output logic signed [COORD_BITS-1:0]       q_y,
   output ncmd_pkg::cfg_type                  q_cfg,
   input  wire logic                          q_take,
   input  wire logic                          back_busy
);
   import ncmd_pkg::*;
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [CLUSTER_BITS-1:0] ncl_ff;
   logic [REPS_BITS-1:0]    reps_ff;
   logic [ENTRIES_BITS-1:0] nent_ff;
   logic                    wr;
   logic [1:0]              ridx;
   logic                    accept;
   logic                    qv_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   cfg_type                 qcfg_ff, snap;
   logic [CLUSTER_BITS-1:0] cl_eff;
   logic [ENTRIES_BITS+AW:0] ent_eff;

   assign ridx = paddr[3:2];
   assign wr   = psel && penable && pwrite;

   always_comb begin
      unique case (ridx)
         2'(CFG_NUM_CLUSTERS): prdata = 32'(ncl_ff);
         2'(CFG_REPS):         prdata = 32'(reps_ff);
         2'(CFG_NUM_ENTRIES):  prdata = 32'(nent_ff);
         default:              prdata = '0;
      endcase
   end

   // One-deep queue; a single query in flight keeps the scan order simple.
   assign busy   = qv_ff || back_busy;
   assign accept = start && !busy;

   always_comb begin
      cl_eff = ncl_ff;
      if (ncl_ff == 0) cl_eff = CLUSTER_BITS'(1);
      else if (32'(ncl_ff) > MAX_CLUSTERS) cl_eff = CLUSTER_BITS'(MAX_CLUSTERS);
      ent_eff = (ENTRIES_BITS+AW+1)'(nent_ff);
      if (32'(nent_ff) > TABLE_DEPTH) ent_eff = (ENTRIES_BITS+AW+1)'(TABLE_DEPTH);
      snap.clusters = cl_eff;
      snap.divisor  = (reps_ff == 0) ? REPS_BITS'(1) : reps_ff;
      snap.entries  = ENTRIES_BITS'(ent_eff);
   end

   assign tbl_wr_en   = accept && req_kind == KIND_LOAD && 32'(req_entry_index) < TABLE_DEPTH;
   assign tbl_wr_addr = AW'(req_entry_index);
   assign tbl_wr_data = {req_point_x, req_point_y, req_entry_cluster};

   assign q_valid = qv_ff;
   assign q_x     = qx_ff;
   assign q_y     = qy_ff;
   assign q_cfg   = qcfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncl_ff  <= CLUSTER_BITS'(1);
         reps_ff <= REPS_BITS'(1);
         nent_ff <= '0;
         qv_ff   <= 1'b0;
      end else begin
         if (wr) begin
            unique case (ridx)
               2'(CFG_NUM_CLUSTERS): ncl_ff  <= pwdata[CLUSTER_BITS-1:0];
               2'(CFG_REPS):         reps_ff <= pwdata[REPS_BITS-1:0];
               2'(CFG_NUM_ENTRIES):  nent_ff <= pwdata[ENTRIES_BITS-1:0];
               default: ;
            endcase
         end
         if (accept && req_kind == KIND_QUERY) qv_ff <= 1'b1;
         else if (q_take) qv_ff <= 1'b0;
      end
      if (accept && req_kind == KIND_QUERY) begin
         qx_ff   <= req_point_x;
         qy_ff   <= req_point_y;
         qcfg_ff <= snap;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/ncmd_back.sv -----
// Back part: per-cluster scan, distance roots, mean and best-cluster selection.
`default_nettype none
module ncmd_back #(
   parameter int TABLE_DEPTH = 256,
   parameter int COORD_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   input  wire logic signed [COORD_BITS-1:0] q_x,
   input  wire logic signed [COORD_BITS-1:0] q_y,
   input  ncmd_pkg::cfg_type                 q_cfg,
   output logic                              q_take,
   output logic                              back_busy,
   output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   input  wire logic [2*COORD_BITS+ncmd_pkg::CLUSTER_BITS-1:0] rd_data,
   output logic                              rsp_valid,
   output logic [ncmd_pkg::CLUSTER_BITS-1:0] rsp_assigned_cluster,
   output logic [ncmd_pkg::MEAN_BITS-1:0]    rsp_mean_distance
);
   import ncmd_pkg::*;
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int DB  = COORD_BITS + 1;
   localparam int SQB = 2 * DB + 1;
   localparam int RTB = (SQB + 1) / 2;
   localparam int SUMB = RTB + REPS_BITS;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_SQ, S_ROOT, S_DIV, S_NEXT} st_type;
   st_type st_ff;

   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   cfg_type                 cfg_ff;
   logic [CLUSTER_BITS-1:0] c_ff;
   logic [ENTRIES_BITS-1:0] p_ff;
   logic [REPS_BITS-1:0]    used_ff;
   logic [SUMB-1:0]         sum_ff;
   logic [DB-1:0]           dx_ff, dy_ff;
   logic [CLUSTER_BITS-1:0] best_c_ff;
   logic [SUMB-1:0]         best_m_ff;
   logic                    rv_ff;

   logic signed [COORD_BITS-1:0] ex, ey;
   logic [CLUSTER_BITS-1:0] el;
   logic signed [DB-1:0]    ddx, ddy;
   logic [2*DB-1:0]         sqx, sqy;
   logic [SQB-1:0]          sq_w;
   logic                    sq_start, sq_done, dv_start, dv_done;
   logic [RTB-1:0]          root;
   logic [SUMB-1:0]         quot;
   logic                    scan_end;

   assign {ex, ey, el} = rd_data;
   assign ddx = DB'(x_ff) - DB'(ex);
   assign ddy = DB'(y_ff) - DB'(ey);
   // squared distance from the registered deltas, taken by the root unit in S_SQ
   assign sqx  = (2*DB)'(dx_ff) * (2*DB)'(dx_ff);
   assign sqy  = (2*DB)'(dy_ff) * (2*DB)'(dy_ff);
   assign sq_w = SQB'(sqx) + SQB'(sqy);
   assign rd_addr = AW'(p_ff);
   assign scan_end = (p_ff >= cfg_ff.entries) || (used_ff == cfg_ff.divisor);
   assign q_take = (st_ff == S_IDLE) && q_valid;
   assign back_busy = (st_ff != S_IDLE);
   assign sq_start = (st_ff == S_SQ);
   assign dv_start = (st_ff == S_READ) && scan_end;

   ncmd_isqrt #(.IN_BITS(SQB)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_w),
      .done(sq_done), .root(root));

   ncmd_divider #(.NUM_BITS(SUMB), .DEN_BITS(REPS_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(sum_ff),
      .divisor(cfg_ff.divisor), .done(dv_done), .quotient(quot));

   assign rsp_valid = rv_ff;
   assign rsp_assigned_cluster = best_c_ff;
   assign rsp_mean_distance = MEAN_BITS'(best_m_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               x_ff <= q_x; y_ff <= q_y; cfg_ff <= q_cfg;
               c_ff <= CLUSTER_BITS'(1); p_ff <= '0; used_ff <= '0; sum_ff <= '0;
               st_ff <= S_READ;
            end
            S_READ: st_ff <= scan_end ? S_DIV : S_CHECK; // ram read in flight
            S_CHECK: begin
               if (el == c_ff) begin
                  dx_ff <= ddx[DB-1] ? DB'(-ddx) : DB'(ddx);
                  dy_ff <= ddy[DB-1] ? DB'(-ddy) : DB'(ddy);
                  st_ff <= S_SQ;
               end else begin
                  p_ff  <= p_ff + 1'b1;
                  st_ff <= S_READ;
               end
            end
            S_SQ: begin
               st_ff <= S_ROOT;
            end
            S_ROOT: if (sq_done) begin
               sum_ff  <= sum_ff + SUMB'(root);
               used_ff <= used_ff + 1'b1;
               p_ff    <= p_ff + 1'b1;
               st_ff   <= S_READ;
            end
            S_DIV: if (dv_done) begin
               if (c_ff == 1 || quot < best_m_ff) begin
                  best_m_ff <= quot;
                  best_c_ff <= c_ff;
               end
               st_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (c_ff == cfg_ff.clusters) begin
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  c_ff <= c_ff + 1'b1; p_ff <= '0; used_ff <= '0; sum_ff <= '0;
                  st_ff <= S_READ;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- rtl/nearest_cluster_by_mean_distance.sv -----
// Top level of the nearest-cluster-by-mean-distance block.
//
// channel | direction | handshake                    | word
// req_    | in        | start & !busy                | kind, index, x, y, label
// rsp_    | out       | rsp_valid, one cycle         | assigned_cluster, mean_distance
// p       | in/out    | psel & penable & pwrite      | 32-bit register
//
// A load is written into the table as it is accepted. A query waits in a
// one-word queue until the back part takes it; then, per cluster, each slot
// is read and checked, each matching slot also runs the 18-step square root,
// and closing the cluster runs the 25-step divider and compare; a cluster's
// scan stops at reps_per_cluster matches or at the last configured entry.
// Reset is synchronous; the table is not cleared. busy is high while a query
// waits or the back part is occupied. The receiver cannot stall results.
`default_nettype none
module nearest_cluster_by_mean_distance #(
   parameter int TABLE_DEPTH  = 256,
   parameter int MAX_CLUSTERS = 16,
   parameter int COORD_BITS   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_kind,
   input  wire logic [7:0]                    req_entry_index,
   input  wire logic signed [COORD_BITS-1:0]  req_point_x,
   input  wire logic signed [COORD_BITS-1:0]  req_point_y,
   input  wire logic [4:0]                    req_entry_cluster,
   output logic                               rsp_valid,
   output logic [4:0]                         rsp_assigned_cluster,
   output logic [16:0]                        rsp_mean_distance,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [3:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import ncmd_pkg::*;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int TW = 2 * COORD_BITS + CLUSTER_BITS;

   logic          wr_en, q_valid, q_take, back_busy;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [TW-1:0] wr_data, rd_data;
   logic signed [COORD_BITS-1:0] q_x, q_y;
   cfg_type       q_cfg;

   assign pready = 1'b1;

   ncmd_front #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CLUSTERS(MAX_CLUSTERS),
                .COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .start, .req_kind, .req_entry_index, .req_point_x,
      .req_point_y, .req_entry_cluster, .psel, .penable, .pwrite, .paddr,
      .pwdata, .prdata, .busy, .tbl_wr_en(wr_en), .tbl_wr_addr(wr_addr),
      .tbl_wr_data(wr_data), .q_valid, .q_x, .q_y, .q_cfg, .q_take, .back_busy);

   // Representative table: x, y and label packed in one word.
   ncmd_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   ncmd_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .q_valid, .q_x, .q_y, .q_cfg, .q_take, .back_busy,
      .rd_addr, .rd_data, .rsp_valid, .rsp_assigned_cluster, .rsp_mean_distance);

   // A result only comes out of a query in progress.
   a_rsp_from_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(back_busy)) else $error("result without a query");
   // Queue is not refilled while a query waits.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !q_take) |=> q_valid) else $error("query lost from queue");
   // A result is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe stuck");
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for nearest_cluster_by_mean_distance: directed and random words.
module tb;
   import ncmd_pkg::*;

   localparam int DEPTH       = 256;
   localparam int MAXCL       = 16;
   localparam int STALL_LIMIT = 200000;   // idle cycles allowed before the watchdog ends the run
   localparam int SETTLE      = 100;      // guard after the block goes idle

   typedef struct {
      logic               kind;
      logic [7:0]         idx;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [4:0]         label;
   } req_word_type;

   typedef struct {
      logic [4:0]  cluster;
      logic [16:0] mean;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = KIND_LOAD;
   logic [7:0] req_entry_index = '0;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic [4:0] req_entry_cluster = '0;
   logic rsp_valid;
   logic [4:0] rsp_assigned_cluster;
   logic [16:0] rsp_mean_distance;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   nearest_cluster_by_mean_distance dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_entry_index(req_entry_index),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_entry_cluster(req_entry_cluster),
      .rsp_valid(rsp_valid), .rsp_assigned_cluster(rsp_assigned_cluster),
      .rsp_mean_distance(rsp_mean_distance),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words waiting for the driver, and answers waiting for the block.
   req_word_type word_q[$];
   answer_type   answer_q[$];

   // Shadow of the block: registers and the representative table.
   logic [4:0]         shadow_clusters = 5'd1;
   logic [6:0]         shadow_reps     = 7'd1;
   logic [8:0]         shadow_entries  = 9'd0;
   logic signed [15:0] shadow_x [DEPTH];
   logic signed [15:0] shadow_y [DEPTH];
   logic [4:0]         shadow_label [DEPTH];

   // Slots already queued for a write; scans never go past written slots.
   bit planned [DEPTH];

   bit quiet = 1'b0;       // no idling in the last part of the run
   int idle_left = 0;
   int mismatches = 0;
   int queries_sent = 0;
   int loads_sent = 0;
   int answers_seen = 0;
   int stall_cycles = 0;

   function automatic longint int_root(input longint n);
      longint r;
      longint t;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // Least mean distance over clusters; ties keep the lower label.
   function automatic answer_type nearest_cluster(input logic signed [15:0] qx,
                                                  input logic signed [15:0] qy);
      answer_type a;
      int      ncl;
      int      div;
      int      scan;
      int      used;
      longint  sum;
      longint  dx;
      longint  dy;
      longint  mean;
      longint  best;
      ncl  = (shadow_clusters == 0) ? 1 : (shadow_clusters > MAXCL ? MAXCL : shadow_clusters);
      div  = (shadow_reps == 0) ? 1 : shadow_reps;
      scan = (shadow_entries > DEPTH) ? DEPTH : shadow_entries;
      a.cluster = 5'd1;
      best = 0;
      for (int c = 1; c <= ncl; c++) begin
         used = 0;
         sum  = 0;
         for (int p = 0; p < scan && used != div; p++) begin
            if (shadow_label[p] == c) begin
               dx = longint'(qx) - longint'(shadow_x[p]);
               dy = longint'(qy) - longint'(shadow_y[p]);
               sum += int_root(dx * dx + dy * dy);
               used++;
            end
         end
         mean = sum / div;
         if (c == 1 || mean < best) begin
            best = mean;
            a.cluster = c[4:0];
         end
      end
      a.mean = best[16:0];
      return a;
   endfunction

   // Driver: a word goes out when start is low or the last one was taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            // Word accepted at this edge: update the shadow or predict the answer.
            if (req_kind == KIND_LOAD) begin
               shadow_x[req_entry_index]     = req_point_x;
               shadow_y[req_entry_index]     = req_point_y;
               shadow_label[req_entry_index] = req_entry_cluster;
            end else begin
               answer_q.insert(answer_q.size(), nearest_cluster(req_point_x, req_point_y));
            end
         end
         if (!start || !busy) begin
            if (idle_left != 0) begin
               idle_left <= idle_left - 1;
               start <= 1'b0;
            end else if (word_q.size() != 0) begin
               req_word_type w;
               w = word_q.pop_front();
               start <= 1'b1;
               req_kind <= w.kind;
               req_entry_index <= w.idx;
               req_point_x <= w.x;
               req_point_y <= w.y;
               req_entry_cluster <= w.label;
               if (!quiet && $urandom_range(0, 9) == 0)
                  idle_left <= $urandom_range(1, 18);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: cluster %0d mean %0d",
                        rsp_assigned_cluster, rsp_mean_distance);
         end else begin
            answer_type e;
            e = answer_q.pop_front();
            if (e.cluster !== rsp_assigned_cluster || e.mean !== rsp_mean_distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected cluster %0d mean %0d, got cluster %0d mean %0d",
                           e.cluster, e.mean, rsp_assigned_cluster, rsp_mean_distance);
            end
         end
      end
   end

   // Watchdog: counts cycles with no handshake on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("nearest_cluster_by_mean_distance test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // APB write: setup cycle, then access; the register takes it at the access edge.
   task automatic write_reg(input int index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CFG_NUM_CLUSTERS: shadow_clusters = value[4:0];
         CFG_REPS:         shadow_reps     = value[6:0];
         CFG_NUM_ENTRIES:  shadow_entries  = value[8:0];
         default: ;
      endcase
   endtask

   task automatic push_load(input int idx, input logic signed [15:0] x,
                            input logic signed [15:0] y, input int label);
      req_word_type w;
      w.kind = KIND_LOAD;
      w.idx = idx[7:0];
      w.x = x;
      w.y = y;
      w.label = label[4:0];
      planned[idx] = 1'b1;
      word_q.insert(word_q.size(), w);
      loads_sent++;
   endtask

   task automatic push_query(input logic signed [15:0] x, input logic signed [15:0] y);
      req_word_type w;
      w.kind = KIND_QUERY;
      // Index and label are don't-care for a query; randomize them anyway.
      w.idx = 8'($urandom);
      w.x = x;
      w.y = y;
      w.label = 5'($urandom_range(0, 16));
      word_q.insert(word_q.size(), w);
      queries_sent++;
   endtask

   // Sampled on the falling edge so driver updates at the rising edge have settled.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (word_q.size() != 0 || start || busy || answer_q.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2, 3:    return 16'($urandom_range(0, 400) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_label(input int ncl);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16);
      return $urandom_range(1, ncl);
   endfunction

   initial begin
      int ncl;
      int nscan;
      int nwords;
      int cl_cfg;
      int reps_cfg;
      int ent_cfg;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: coordinate extremes, an empty slot, a label beyond the
      // cluster count, a cluster with more slots than used, a short cluster,
      // the top slot index.
      write_reg(CFG_NUM_CLUSTERS, 3);
      write_reg(CFG_REPS, 2);
      write_reg(CFG_NUM_ENTRIES, 8);
      push_load(0, 16'sh7fff, 16'sh7fff, 1);
      push_load(1, 16'sh8000, 16'sh8000, 2);
      push_load(2, 16'sh0000, 16'sh0000, 1);
      push_load(3, 16'sh0100, 16'shff00, 0);
      push_load(4, 16'sh0000, 16'sh0001, 16);
      push_load(5, 16'sh0010, 16'sh0010, 1);
      push_load(6, 16'sh8000, 16'sh7fff, 2);
      push_load(7, 16'sh0040, 16'shffc0, 3);
      push_load(255, 16'sh7fff, 16'sh8000, 2);
      push_query(16'sh8000, 16'sh8000);
      push_query(16'sh7fff, 16'sh7fff);
      push_query(16'sh0000, 16'sh0000);
      push_query(16'sh7fff, 16'sh8000);
      push_query(16'sh0040, 16'shffc0);
      wait_for_idle();
      // Cluster 3 loses its only slot: an empty cluster has mean zero.
      push_load(7, 16'sh0000, 16'sh0000, 0);
      push_query(16'sh1234, 16'sh4321);
      wait_for_idle();

      for (int ph = 0; ph < 13; ph++) begin
         case (ph)
            0: begin cl_cfg = 0;  reps_cfg = 0;   ent_cfg = 0;   end
            1: begin cl_cfg = 31; reps_cfg = 127; ent_cfg = 511; end
            2: begin cl_cfg = 16; reps_cfg = 64;  ent_cfg = 256; end
            3: begin cl_cfg = 16; reps_cfg = 1;   ent_cfg = 24;  end
            default: begin
               cl_cfg   = $urandom_range(1, 6);
               reps_cfg = $urandom_range(1, 8);
               ent_cfg  = $urandom_range(1, 24);
            end
         endcase
         quiet = (ph >= 11);
         write_reg(CFG_NUM_CLUSTERS, cl_cfg);
         write_reg(CFG_REPS, reps_cfg);
         write_reg(CFG_NUM_ENTRIES, ent_cfg);
         ncl   = (cl_cfg == 0) ? 1 : (cl_cfg > MAXCL ? MAXCL : cl_cfg);
         nscan = (ent_cfg > DEPTH) ? DEPTH : ent_cfg;
         // Every scanned slot is written before the first query.
         for (int i = 0; i < nscan; i++)
            if (!planned[i]) push_load(i, pick_coord(), pick_coord(), pick_label(ncl));
         nwords = (ph == 1 || ph == 2) ? 12 : 100;
         for (int k = 0; k < nwords; k++) begin
            if ($urandom_range(0, 9) < 6)
               push_query(pick_coord(), pick_coord());
            else
               push_load($urandom_range(0, 255), pick_coord(), pick_coord(), pick_label(ncl));
         end
         wait_for_idle();
      end

      if (answer_q.size() != 0) begin
         mismatches += answer_q.size();
         $display("%0d expected results never arrived", answer_q.size());
      end
      $display("covered %0d load words and %0d queries over 14 register settings",
               loads_sent, queries_sent);
      $display("%0d results checked, %0d mismatches", answers_seen, mismatches);
      if (mismatches == 0)
         $display("nearest_cluster_by_mean_distance test passed");
      else
         $display("nearest_cluster_by_mean_distance test failed");
      $finish;
   end
endmodule
